// ----- sv/e2r_pkg.sv -----
package e2r_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int ENTRY_FRAC_BITS = 14;
  localparam int CORDIC_STAGES   = 16;
  localparam int WORK_FRAC       = 30;
  localparam int WW              = 34;   // cordic x/y and z width
  localparam int PW              = 2 * WW;

  localparam logic signed [WW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [WW-1:0] QUARTER     = 34'sd1073741824;
  localparam logic signed [WW-1:0] HALF        = 34'sd2147483648;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic                         inverse;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r13;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r23;
    logic signed [15:0] r31;
    logic signed [15:0] r32;
    logic signed [15:0] r33;
  } out_word_t;

  // one cordic lane: x, y, z plus fold sign
  typedef struct packed {
    logic signed [WW-1:0] x;
    logic signed [WW-1:0] y;
    logic signed [WW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;
    logic        inverse;
    logic        vld;
  } cell_data_t;

  function automatic logic signed [WW-1:0] atan_turn(input int k);
    logic signed [WW-1:0] t;
    case (k)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;
      2: t = 34'sd167458907;   3: t = 34'sd85004756;
      4: t = 34'sd42667331;    5: t = 34'sd21354465;
      6: t = 34'sd10679838;    7: t = 34'sd5340245;
      8: t = 34'sd2670163;     9: t = 34'sd1335087;
      10: t = 34'sd667544;     11: t = 34'sd333772;
      12: t = 34'sd166886;     13: t = 34'sd83443;
      14: t = 34'sd41722;      15: t = 34'sd20861;
      16: t = 34'sd10430;      17: t = 34'sd5215;
      18: t = 34'sd2608;       19: t = 34'sd1304;
      20: t = 34'sd652;        21: t = 34'sd326;
      22: t = 34'sd163;        23: t = 34'sd81;
      24: t = 34'sd41;         25: t = 34'sd20;
      26: t = 34'sd10;         27: t = 34'sd5;
      28: t = 34'sd3;          29: t = 34'sd1;
      30: t = 34'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // product of two q.30 values rounded back to q.30
  function automatic logic signed [WW-1:0] qmul(input logic signed [WW-1:0] a,
                                               input logic signed [WW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (WORK_FRAC - 1));
    return WW'(p >>> WORK_FRAC);
  endfunction

  function automatic logic signed [15:0] to_entry(input logic signed [WW-1:0] v);
    logic signed [WW:0] r;
    logic signed [WW:0] one;
    one = (WW+1)'(1) <<< ENTRY_FRAC_BITS;
    if (WORK_FRAC > ENTRY_FRAC_BITS)
      r = ((WW+1)'(v) + ((WW+1)'(1) <<< (WORK_FRAC - ENTRY_FRAC_BITS - 1)))
          >>> (WORK_FRAC - ENTRY_FRAC_BITS);
    else
      r = (WW+1)'(v);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

endpackage

// ----- sv/e2r_cell.sv -----
module e2r_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [4:0]             shift,
  input  e2r_pkg::cell_data_t    din,
  output e2r_pkg::cell_data_t    dout
);

  e2r_pkg::cell_data_t dout_next;

  always_comb begin
    dout_next = din;
    for (int l = 0; l < 3; l++) begin
      if (!din.lane[l].z[e2r_pkg::WW-1]) begin
        dout_next.lane[l].x = din.lane[l].x - (din.lane[l].y >>> shift);
        dout_next.lane[l].y = din.lane[l].y + (din.lane[l].x >>> shift);
        dout_next.lane[l].z = din.lane[l].z - e2r_pkg::atan_turn(int'(shift));
      end else begin
        dout_next.lane[l].x = din.lane[l].x + (din.lane[l].y >>> shift);
        dout_next.lane[l].y = din.lane[l].y - (din.lane[l].x >>> shift);
        dout_next.lane[l].z = din.lane[l].z + e2r_pkg::atan_turn(int'(shift));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.lane    <= dout_next.lane;
      dout.inverse <= dout_next.inverse;
    end
  end

endmodule

// ----- sv/e2r_matrix.sv -----
module e2r_matrix (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  e2r_pkg::cell_data_t  din,
  output logic                 vld,
  output e2r_pkg::out_word_t   dout
);

  localparam int WW = e2r_pkg::WW;

  logic signed [WW-1:0] s_cr, s_sr, s_cp, s_sp, s_cy, s_sy;
  logic signed [WW-1:0] cr, sr, cp, sp, cy, sy;
  logic signed [WW-1:0] m0, m3, m7, m8, cysp, sysp, sycr, sysr, cycr, cysr;
  logic signed [WW-1:0] a_cr, a_sr, a_sp;
  logic signed [WW-1:0] m1, m2, m4, m5, m6, b0, b3, b7, b8;
  logic                 v1, v2, v3, inv1, inv2, inv3;
  logic signed [WW-1:0] e [9];
  e2r_pkg::out_word_t   dout_next;

  // undo quarter-turn fold
  assign s_cr = din.lane[0].neg ? -din.lane[0].x : din.lane[0].x;
  assign s_sr = din.lane[0].neg ? -din.lane[0].y : din.lane[0].y;
  assign s_cp = din.lane[1].neg ? -din.lane[1].x : din.lane[1].x;
  assign s_sp = din.lane[1].neg ? -din.lane[1].y : din.lane[1].y;
  assign s_cy = din.lane[2].neg ? -din.lane[2].x : din.lane[2].x;
  assign s_sy = din.lane[2].neg ? -din.lane[2].y : din.lane[2].y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vld <= 1'b0;
    end else if (en) begin
      v1 <= din.vld;
      v2 <= v1;
      v3 <= v2;
      vld <= v3;
    end
    if (en) begin
      cr <= s_cr; sr <= s_sr; cp <= s_cp; sp <= s_sp; cy <= s_cy; sy <= s_sy;
      inv1 <= din.inverse;
      // first products
      m0 <= e2r_pkg::qmul(cy, cp);
      m3 <= e2r_pkg::qmul(sy, cp);
      m7 <= e2r_pkg::qmul(cp, sr);
      m8 <= e2r_pkg::qmul(cp, cr);
      cysp <= e2r_pkg::qmul(cy, sp);
      sysp <= e2r_pkg::qmul(sy, sp);
      sycr <= e2r_pkg::qmul(sy, cr);
      sysr <= e2r_pkg::qmul(sy, sr);
      cycr <= e2r_pkg::qmul(cy, cr);
      cysr <= e2r_pkg::qmul(cy, sr);
      a_cr <= cr; a_sr <= sr; a_sp <= sp;
      inv2 <= inv1;
      // second products and sums
      m1 <= e2r_pkg::qmul(cysp, a_sr) - sycr;
      m2 <= e2r_pkg::qmul(cysp, a_cr) + sysr;
      m4 <= e2r_pkg::qmul(sysp, a_sr) + cycr;
      m5 <= e2r_pkg::qmul(sysp, a_cr) - cysr;
      m6 <= -a_sp;
      b0 <= m0; b3 <= m3; b7 <= m7; b8 <= m8;
      inv3 <= inv2;
      dout <= dout_next;
    end
  end

  always_comb begin
    e[0] = b0; e[4] = m4; e[8] = b8;
    e[1] = inv3 ? b3 : m1;  e[3] = inv3 ? m1 : b3;
    e[2] = inv3 ? m6 : m2;  e[6] = inv3 ? m2 : m6;
    e[5] = inv3 ? b7 : m5;  e[7] = inv3 ? m5 : b7;
    dout_next.r11 = e2r_pkg::to_entry(e[0]);
    dout_next.r12 = e2r_pkg::to_entry(e[1]);
    dout_next.r13 = e2r_pkg::to_entry(e[2]);
    dout_next.r21 = e2r_pkg::to_entry(e[3]);
    dout_next.r22 = e2r_pkg::to_entry(e[4]);
    dout_next.r23 = e2r_pkg::to_entry(e[5]);
    dout_next.r31 = e2r_pkg::to_entry(e[6]);
    dout_next.r32 = e2r_pkg::to_entry(e[7]);
    dout_next.r33 = e2r_pkg::to_entry(e[8]);
  end

endmodule

// ----- sv/euler_to_rotation_matrix.sv -----
// channel | direction | payload                     | handshake
// in      | input     | e2r_pkg::in_word_t  (49 b)  | in_valid / in_stall
// out     | output    | e2r_pkg::out_word_t (144 b) | out_valid / out_stall
//
// one word per cycle while the output is not blocked; CORDIC_STAGES + 5
// register stages (fold register, 16 cordic cells, sign register, two
// multiply stages, rounding register)
// the whole pipeline advances together; an out_stall while out_valid is
// high freezes every stage and raises in_stall, so the output word stays put
// rst is synchronous and clears only the valid bits along the chain
module euler_to_rotation_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  e2r_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output e2r_pkg::out_word_t out_data
);

  localparam int WW = e2r_pkg::WW;
  localparam int N  = e2r_pkg::CORDIC_STAGES;

  logic                en;
  e2r_pkg::cell_data_t chain [N+1];
  e2r_pkg::cell_data_t head_next;

  // stall only when the output word is blocked
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // angle to 32-bit turn, then fold into +-quarter turn
  function automatic e2r_pkg::lane_t fold(input logic signed [e2r_pkg::ANGLE_BITS-1:0] a);
    e2r_pkg::lane_t       l;
    logic signed [WW-1:0] z;
    z = WW'(a) <<< (32 - e2r_pkg::ANGLE_BITS);
    l.x = e2r_pkg::CORDIC_GAIN;
    l.y = '0;
    l.neg = 1'b0;
    if (z > e2r_pkg::QUARTER) begin
      z = z - e2r_pkg::HALF;
      l.neg = 1'b1;
    end else if (z < -e2r_pkg::QUARTER) begin
      z = z + e2r_pkg::HALF;
      l.neg = 1'b1;
    end
    l.z = z;
    return l;
  endfunction

  always_comb begin
    head_next.lane[0] = fold(in_data.roll_angle);
    head_next.lane[1] = fold(in_data.pitch_angle);
    head_next.lane[2] = fold(in_data.yaw_angle);
    head_next.inverse = in_data.inverse;
    head_next.vld     = in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0].vld <= head_next.vld;
    end
    if (en) begin
      chain[0].lane    <= head_next.lane;
      chain[0].inverse <= head_next.inverse;
    end
  end

  // row of cordic cells, one micro-rotation each
  for (genvar i = 0; i < N; i++) begin : g_cell
    e2r_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .shift (5'(i)),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  e2r_matrix u_matrix (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (chain[N]),
    .vld  (out_valid),
    .dout (out_data)
  );

  a_stall_only_on_block: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  a_hold_on_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_chain_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(chain[N].vld))
    else $error("cordic chain moved during a stall");

endmodule
